### rtl/http_request_header_parser_assert.svh
// Assertion macros used by the parser top level.
`ifndef HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define HRP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define HRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/hrp_pkg.sv
package hrp_pkg;

  typedef enum logic [1:0] {
    VERDICT_MORE = 2'd0,
    VERDICT_DONE = 2'd1,
    VERDICT_BAD  = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_METHOD    = 3'd1,
    KIND_URI       = 3'd2,
    KIND_HDR_NAME  = 3'd3,
    KIND_HDR_VALUE = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       is_token;
    logic       is_ctl;
    logic       is_dec;
    logic       is_lws;
  } cls_t;

  localparam logic [7:0] CHAR_LAST   = 8'd127;
  localparam logic [7:0] CTL_LAST    = 8'd31;
  localparam logic [7:0] VERSION_MAX = 8'd255;
  localparam logic [3:0] DIGIT_BASE  = 4'd10;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;
  localparam logic [7:0] ASCII_CR    = 8'h0D;
  localparam logic [7:0] ASCII_LF    = 8'h0A;
  localparam logic [7:0] ASCII_SP    = 8'h20;
  localparam logic [7:0] ASCII_TAB   = 8'h09;
  localparam logic [7:0] ASCII_COLON = 8'h3A;
  localparam logic [7:0] ASCII_DOT   = 8'h2E;
  localparam logic [7:0] ASCII_SLASH = 8'h2F;
  localparam logic [7:0] ASCII_H     = 8'h48;
  localparam logic [7:0] ASCII_T     = 8'h54;
  localparam logic [7:0] ASCII_P     = 8'h50;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // value * 10 + digit, saturating
  function automatic logic [7:0] acc_digit(logic [7:0] value, logic [3:0] digit);
    logic [11:0] prod;
    logic [11:0] sum;
    prod = 12'(value) * 12'(DIGIT_BASE);
    sum  = prod + 12'(digit);
    return (sum > 12'(VERSION_MAX)) ? VERSION_MAX : sum[7:0];
  endfunction

endpackage

### rtl/hrp_if.sv
interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_request;

  modport source (output valid, data_byte, start_request, input ready);
  modport sink (input valid, data_byte, start_request, output ready);
endinterface

interface hrp_out_if;
  logic             valid;
  logic             ready;
  hrp_pkg::verdict_t verdict;
  hrp_pkg::kind_t    byte_kind;
  logic             new_header;
  logic [7:0]       char_out;
  logic [7:0]       version_major;
  logic [7:0]       version_minor;

  modport source (output valid, verdict, byte_kind, new_header, char_out,
                  version_major, version_minor, input ready);
  modport sink (input valid, verdict, byte_kind, new_header, char_out,
                version_major, version_minor, output ready);
endinterface

interface hrp_cls_if;
  logic          valid;
  logic          ready;
  hrp_pkg::cls_t cls;

  modport source (output valid, cls, input ready);
  modport sink (input valid, cls, output ready);
endinterface

### rtl/hrp_front.sv
module hrp_front (
  hrp_in_if.sink   request,
  hrp_cls_if.source cls_out
);
  import hrp_pkg::*;

  logic [7:0] b;
  logic       is_sep;
  logic       is_ctl;

  assign b = request.data_byte;

  always_comb begin
    unique case (b)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: begin
        is_sep = 1'b1;
      end
      default: begin
        is_sep = 1'b0;
      end
    endcase
  end

  assign is_ctl = (b <= CTL_LAST) || (b == CHAR_LAST);

  // classify each request byte
  assign cls_out.cls.data     = b;
  assign cls_out.cls.start    = request.start_request;
  assign cls_out.cls.is_ctl   = is_ctl;
  assign cls_out.cls.is_token = (b <= CHAR_LAST) && !is_ctl && !is_sep;
  assign cls_out.cls.is_dec   = (b >= ASCII_ZERO) && (b <= ASCII_NINE);
  assign cls_out.cls.is_lws   = (b == ASCII_SP) || (b == ASCII_TAB);

  assign cls_out.valid  = request.valid;
  assign request.ready  = cls_out.ready;

endmodule

### rtl/hrp_queue.sv
module hrp_queue (
  input  logic      clk,
  input  logic      rst,
  hrp_cls_if.sink   push,
  hrp_cls_if.source pop
);
  import hrp_pkg::*;

  localparam logic [QUEUE_AW:0] FULL_COUNT = (QUEUE_AW + 1)'(QUEUE_DEPTH);

  cls_t                entry [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push.ready = (count != FULL_COUNT);
  assign pop.valid  = (count != '0);
  assign pop.cls    = entry[rd_ptr];

  assign do_push = push.valid && push.ready;
  assign do_pop  = pop.valid && pop.ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push.cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/hrp_back.sv
module hrp_back (
  input  logic      clk,
  input  logic      rst,
  hrp_cls_if.sink   cls_in,
  hrp_out_if.source result
);
  import hrp_pkg::*;

  typedef enum logic [4:0] {
    ST_METHOD_START  = 5'd0,
    ST_METHOD        = 5'd1,
    ST_URI_START     = 5'd2,
    ST_URI           = 5'd3,
    ST_VER_H         = 5'd4,
    ST_VER_T1        = 5'd5,
    ST_VER_T2        = 5'd6,
    ST_VER_P         = 5'd7,
    ST_VER_SLASH     = 5'd8,
    ST_MAJOR_START   = 5'd9,
    ST_MAJOR         = 5'd10,
    ST_MINOR_START   = 5'd11,
    ST_MINOR         = 5'd12,
    ST_NL_1          = 5'd13,
    ST_HDR_START     = 5'd14,
    ST_HDR_LWS       = 5'd15,
    ST_HDR_NAME      = 5'd16,
    ST_SP_BEFORE_VAL = 5'd17,
    ST_HDR_VALUE     = 5'd18,
    ST_NL_2          = 5'd19,
    ST_NL_3          = 5'd20
  } state_t;

  state_t     state;
  state_t     state_cur;
  state_t     state_next;
  logic       have_header;
  logic       hh_cur;
  logic       have_header_next;
  logic [7:0] major_count;
  logic [7:0] major_count_next;
  logic [7:0] minor_count;
  logic [7:0] minor_count_next;

  logic       out_valid;
  verdict_t   verdict;
  verdict_t   verdict_next;
  kind_t      byte_kind;
  kind_t      byte_kind_next;
  logic       new_header;
  logic       new_header_next;
  logic [7:0] char_out;

  cls_t       c;
  logic [7:0] b;
  logic [3:0] digit;
  logic       take;

  assign c     = cls_in.cls;
  assign b     = c.data;
  assign digit = 4'(b - ASCII_ZERO);

  assign cls_in.ready = !out_valid || result.ready;
  assign take         = cls_in.valid && cls_in.ready;

  always_comb begin
    state_cur        = c.start ? ST_METHOD_START : state;
    hh_cur           = c.start ? 1'b0 : have_header;
    state_next       = state_cur;
    have_header_next = hh_cur;
    major_count_next = major_count;
    minor_count_next = minor_count;
    verdict_next     = VERDICT_MORE;
    byte_kind_next   = KIND_NONE;
    new_header_next  = 1'b0;

    unique case (state_cur)
      ST_METHOD_START: begin
        if (c.is_token) begin
          state_next     = ST_METHOD;
          byte_kind_next = KIND_METHOD;
        end else begin
          verdict_next = VERDICT_BAD;
        end
      end
      ST_METHOD: begin
        priority if (b == ASCII_SP) begin
          state_next = ST_URI_START;
        end else if (c.is_token) begin
          byte_kind_next = KIND_METHOD;
        end else begin
          verdict_next = VERDICT_BAD;
        end
      end
      ST_URI_START: begin
        if (c.is_ctl) begin
          verdict_next = VERDICT_BAD;
        end else begin
          state_next     = ST_URI;
          byte_kind_next = KIND_URI;
        end
      end
      ST_URI: begin
        priority if (b == ASCII_SP) begin
          state_next = ST_VER_H;
        end else if (c.is_ctl) begin
          verdict_next = VERDICT_BAD;
        end else begin
          byte_kind_next = KIND_URI;
        end
      end
      ST_VER_H: begin
        if (b == ASCII_H) state_next = ST_VER_T1;
        else verdict_next = VERDICT_BAD;
      end
      ST_VER_T1: begin
        if (b == ASCII_T) state_next = ST_VER_T2;
        else verdict_next = VERDICT_BAD;
      end
      ST_VER_T2: begin
        if (b == ASCII_T) state_next = ST_VER_P;
        else verdict_next = VERDICT_BAD;
      end
      ST_VER_P: begin
        if (b == ASCII_P) state_next = ST_VER_SLASH;
        else verdict_next = VERDICT_BAD;
      end
      ST_VER_SLASH: begin
        if (b == ASCII_SLASH) begin
          major_count_next = '0;
          minor_count_next = '0;
          state_next       = ST_MAJOR_START;
        end else begin
          verdict_next = VERDICT_BAD;
        end
      end
      ST_MAJOR_START: begin
        if (c.is_dec) begin
          major_count_next = acc_digit(major_count, digit);
          state_next       = ST_MAJOR;
        end else begin
          verdict_next = VERDICT_BAD;
        end
      end
      ST_MAJOR: begin
        priority if (b == ASCII_DOT) begin
          state_next = ST_MINOR_START;
        end else if (c.is_dec) begin
          major_count_next = acc_digit(major_count, digit);
        end else begin
          verdict_next = VERDICT_BAD;
        end
      end
      ST_MINOR_START: begin
        if (c.is_dec) begin
          minor_count_next = acc_digit(minor_count, digit);
          state_next       = ST_MINOR;
        end else begin
          verdict_next = VERDICT_BAD;
        end
      end
      ST_MINOR: begin
        priority if (b == ASCII_CR) begin
          state_next = ST_NL_1;
        end else if (c.is_dec) begin
          minor_count_next = acc_digit(minor_count, digit);
        end else begin
          verdict_next = VERDICT_BAD;
        end
      end
      ST_NL_1: begin
        if (b == ASCII_LF) state_next = ST_HDR_START;
        else verdict_next = VERDICT_BAD;
      end
      ST_HDR_START: begin
        priority if (b == ASCII_CR) begin
          state_next = ST_NL_3;
        end else if (hh_cur && c.is_lws) begin
          state_next = ST_HDR_LWS;
        end else if (c.is_token) begin
          have_header_next = 1'b1;
          new_header_next  = 1'b1;
          byte_kind_next   = KIND_HDR_NAME;
          state_next       = ST_HDR_NAME;
        end else begin
          verdict_next = VERDICT_BAD;
        end
      end
      ST_HDR_LWS: begin
        priority if (b == ASCII_CR) begin
          state_next = ST_NL_2;
        end else if (c.is_lws) begin
          state_next = ST_HDR_LWS;
        end else if (c.is_ctl) begin
          verdict_next = VERDICT_BAD;
        end else begin
          state_next     = ST_HDR_VALUE;
          byte_kind_next = KIND_HDR_VALUE;
        end
      end
      ST_HDR_NAME: begin
        priority if (b == ASCII_COLON) begin
          state_next = ST_SP_BEFORE_VAL;
        end else if (c.is_token) begin
          byte_kind_next = KIND_HDR_NAME;
        end else begin
          verdict_next = VERDICT_BAD;
        end
      end
      ST_SP_BEFORE_VAL: begin
        if (b == ASCII_SP) state_next = ST_HDR_VALUE;
        else verdict_next = VERDICT_BAD;
      end
      ST_HDR_VALUE: begin
        priority if (b == ASCII_CR) begin
          state_next = ST_NL_2;
        end else if (c.is_ctl) begin
          verdict_next = VERDICT_BAD;
        end else begin
          byte_kind_next = KIND_HDR_VALUE;
        end
      end
      ST_NL_2: begin
        if (b == ASCII_LF) state_next = ST_HDR_START;
        else verdict_next = VERDICT_BAD;
      end
      ST_NL_3: begin
        verdict_next = (b == ASCII_LF) ? VERDICT_DONE : VERDICT_BAD;
      end
      default: begin
        verdict_next = VERDICT_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_METHOD_START;
      have_header <= 1'b0;
      major_count <= '0;
      minor_count <= '0;
      out_valid   <= 1'b0;
    end else if (take) begin
      state       <= state_next;
      have_header <= have_header_next;
      major_count <= major_count_next;
      minor_count <= minor_count_next;
      out_valid   <= 1'b1;
      verdict     <= verdict_next;
      byte_kind   <= byte_kind_next;
      new_header  <= new_header_next;
      char_out    <= b;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid         = out_valid;
  assign result.verdict       = verdict;
  assign result.byte_kind     = byte_kind;
  assign result.new_header    = new_header;
  assign result.char_out      = char_out;
  assign result.version_major = major_count;
  assign result.version_minor = minor_count;

endmodule

### rtl/http_request_header_parser.sv
// Channel   Role    Handshake      Payload
// request   sink    valid/ready    data_byte[7:0], start_request
// result    source  valid/ready    verdict, byte_kind, new_header, char_out,
//                                  version_major, version_minor
//
// One request byte per cycle sustained while result ready stays high; one result per byte.
// Each byte is classified into a two-entry queue, then the parse state
// machine writes the output register.
// rst is synchronous; it returns the parser to the method start with
// cleared version counts and empties the queue.
// A stalled result holds; request ready drops only when the queue is full.
`include "http_request_header_parser_assert.svh"

module http_request_header_parser (
  input logic       clk,
  input logic       rst,
  hrp_in_if.sink    request,
  hrp_out_if.source result
);
  import hrp_pkg::*;

  hrp_cls_if front_q ();
  hrp_cls_if q_back ();

  hrp_front u_front (
    .request (request),
    .cls_out (front_q)
  );

  hrp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (front_q),
    .pop  (q_back)
  );

  hrp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cls_in (q_back),
    .result (result)
  );

  `HRP_ASSERT_NEXT(a_req_queued, request.valid && request.ready, q_back.valid, "accepted request not queued")
  `HRP_ASSERT_NEXT(a_queue_drains, q_back.valid && !result.valid, result.valid, "queued request not parsed")
  `HRP_ASSERT_IMP(a_bad_clean, result.valid && result.verdict == VERDICT_BAD, result.byte_kind == KIND_NONE && !result.new_header, "malformed byte carries a tag")
  `HRP_ASSERT_IMP(a_newh_name, result.valid && result.new_header, result.byte_kind == KIND_HDR_NAME && result.verdict == VERDICT_MORE, "new header not on a name byte")

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import hrp_pkg::*;

  typedef enum logic [4:0] {
    PS_METHOD_START, PS_METHOD, PS_URI_START, PS_URI, PS_VER_H, PS_VER_T1,
    PS_VER_T2, PS_VER_P, PS_VER_SLASH, PS_MAJOR_START, PS_MAJOR,
    PS_MINOR_START, PS_MINOR, PS_NL_1, PS_HDR_START, PS_HDR_LWS, PS_HDR_NAME,
    PS_SP_BEFORE_VAL, PS_HDR_VALUE, PS_NL_2, PS_NL_3
  } parse_state_t;

  typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} sink_mode_t;

  typedef struct {
    verdict_t   verdict;
    kind_t      kind;
    logic       new_hdr;
    logic [7:0] ch;
    logic [7:0] major;
    logic [7:0] minor;
  } parse_result_t;

  class parse_scoreboard;
    parse_state_t  state;
    logic          have_hdr;
    logic [7:0]    major_cnt;
    logic [7:0]    minor_cnt;
    parse_result_t pending[$];
    int            errors;
    int            checked;
    int            done_cnt;
    int            bad_cnt;

    function new();
      state     = PS_METHOD_START;
      have_hdr  = 1'b0;
      major_cnt = 8'd0;
      minor_cnt = 8'd0;
      errors    = 0;
      checked   = 0;
      done_cnt  = 0;
      bad_cnt   = 0;
    endfunction

    function bit is_ctl(logic [7:0] b);
      return (b <= CTL_LAST) || (b == CHAR_LAST);
    endfunction

    function bit is_num(logic [7:0] b);
      return (b >= ASCII_ZERO) && (b <= ASCII_NINE);
    endfunction

    function bit is_token(logic [7:0] b);
      bit sep;
      case (b)
        "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
        "=", "{", "}", ASCII_SP, ASCII_TAB: sep = 1'b1;
        default: sep = 1'b0;
      endcase
      return (b <= CHAR_LAST) && !is_ctl(b) && !sep;
    endfunction

    function logic [7:0] digit_step(logic [7:0] v, logic [7:0] b);
      int n;
      n = int'(v) * 10 + int'(b) - int'(ASCII_ZERO);
      return (n > 255) ? VERSION_MAX : n[7:0];
    endfunction

    function void note_request(logic [7:0] b, logic s);
      parse_result_t r;
      parse_state_t  nxt;
      if (s) begin
        state    = PS_METHOD_START;
        have_hdr = 1'b0;
      end
      nxt       = state;
      r.verdict = VERDICT_MORE;
      r.kind    = KIND_NONE;
      r.new_hdr = 1'b0;
      case (state)
        PS_METHOD_START: begin
          if (is_token(b)) begin
            nxt    = PS_METHOD;
            r.kind = KIND_METHOD;
          end else r.verdict = VERDICT_BAD;
        end
        PS_METHOD: begin
          if (b == ASCII_SP) nxt = PS_URI_START;
          else if (is_token(b)) r.kind = KIND_METHOD;
          else r.verdict = VERDICT_BAD;
        end
        PS_URI_START: begin
          if (is_ctl(b)) r.verdict = VERDICT_BAD;
          else begin
            nxt    = PS_URI;
            r.kind = KIND_URI;
          end
        end
        PS_URI: begin
          if (b == ASCII_SP) nxt = PS_VER_H;
          else if (is_ctl(b)) r.verdict = VERDICT_BAD;
          else r.kind = KIND_URI;
        end
        PS_VER_H: if (b == ASCII_H) nxt = PS_VER_T1; else r.verdict = VERDICT_BAD;
        PS_VER_T1: if (b == ASCII_T) nxt = PS_VER_T2; else r.verdict = VERDICT_BAD;
        PS_VER_T2: if (b == ASCII_T) nxt = PS_VER_P; else r.verdict = VERDICT_BAD;
        PS_VER_P: if (b == ASCII_P) nxt = PS_VER_SLASH; else r.verdict = VERDICT_BAD;
        PS_VER_SLASH: begin
          if (b == ASCII_SLASH) begin
            major_cnt = 8'd0;
            minor_cnt = 8'd0;
            nxt       = PS_MAJOR_START;
          end else r.verdict = VERDICT_BAD;
        end
        PS_MAJOR_START: begin
          if (is_num(b)) begin
            major_cnt = digit_step(major_cnt, b);
            nxt       = PS_MAJOR;
          end else r.verdict = VERDICT_BAD;
        end
        PS_MAJOR: begin
          if (b == ASCII_DOT) nxt = PS_MINOR_START;
          else if (is_num(b)) major_cnt = digit_step(major_cnt, b);
          else r.verdict = VERDICT_BAD;
        end
        PS_MINOR_START: begin
          if (is_num(b)) begin
            minor_cnt = digit_step(minor_cnt, b);
            nxt       = PS_MINOR;
          end else r.verdict = VERDICT_BAD;
        end
        PS_MINOR: begin
          if (b == ASCII_CR) nxt = PS_NL_1;
          else if (is_num(b)) minor_cnt = digit_step(minor_cnt, b);
          else r.verdict = VERDICT_BAD;
        end
        PS_NL_1: if (b == ASCII_LF) nxt = PS_HDR_START; else r.verdict = VERDICT_BAD;
        PS_HDR_START: begin
          if (b == ASCII_CR) nxt = PS_NL_3;
          else if (have_hdr && (b == ASCII_SP || b == ASCII_TAB)) nxt = PS_HDR_LWS;
          else if (is_token(b)) begin
            have_hdr  = 1'b1;
            r.new_hdr = 1'b1;
            r.kind    = KIND_HDR_NAME;
            nxt       = PS_HDR_NAME;
          end else r.verdict = VERDICT_BAD;
        end
        PS_HDR_LWS: begin
          if (b == ASCII_CR) nxt = PS_NL_2;
          else if (b == ASCII_SP || b == ASCII_TAB) nxt = PS_HDR_LWS;
          else if (is_ctl(b)) r.verdict = VERDICT_BAD;
          else begin
            nxt    = PS_HDR_VALUE;
            r.kind = KIND_HDR_VALUE;
          end
        end
        PS_HDR_NAME: begin
          if (b == ASCII_COLON) nxt = PS_SP_BEFORE_VAL;
          else if (is_token(b)) r.kind = KIND_HDR_NAME;
          else r.verdict = VERDICT_BAD;
        end
        PS_SP_BEFORE_VAL: begin
          if (b == ASCII_SP) nxt = PS_HDR_VALUE;
          else r.verdict = VERDICT_BAD;
        end
        PS_HDR_VALUE: begin
          if (b == ASCII_CR) nxt = PS_NL_2;
          else if (is_ctl(b)) r.verdict = VERDICT_BAD;
          else r.kind = KIND_HDR_VALUE;
        end
        PS_NL_2: if (b == ASCII_LF) nxt = PS_HDR_START; else r.verdict = VERDICT_BAD;
        PS_NL_3: r.verdict = (b == ASCII_LF) ? VERDICT_DONE : VERDICT_BAD;
        default: r.verdict = VERDICT_BAD;
      endcase
      state   = nxt;
      r.ch    = b;
      r.major = major_cnt;
      r.minor = minor_cnt;
      if (r.verdict == VERDICT_DONE) done_cnt++;
      if (r.verdict == VERDICT_BAD) bad_cnt++;
      pending = {pending, r};
    endfunction

    function void check_result(verdict_t v, kind_t k, logic nh, logic [7:0] ch,
                               logic [7:0] maj, logic [7:0] mnr);
      parse_result_t e;
      if (pending.size() == 0) begin
        $error("result with no request pending: char_out %0h", ch);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (v !== e.verdict) begin
        $error("verdict: expected %0d, got %0d", e.verdict, v);
        errors++;
      end
      if (k !== e.kind) begin
        $error("byte_kind: expected %0d, got %0d", e.kind, k);
        errors++;
      end
      if (nh !== e.new_hdr) begin
        $error("new_header: expected %0d, got %0d", e.new_hdr, nh);
        errors++;
      end
      if (ch !== e.ch) begin
        $error("char_out: expected %0h, got %0h", e.ch, ch);
        errors++;
      end
      if (maj !== e.major) begin
        $error("version_major: expected %0d, got %0d", e.major, maj);
        errors++;
      end
      if (mnr !== e.minor) begin
        $error("version_minor: expected %0d, got %0d", e.minor, mnr);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  hrp_in_if  req_if ();
  hrp_out_if res_if ();

  http_request_header_parser u_top (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (res_if)
  );

  parse_scoreboard sb = new();
  logic [7:0]      wire_bytes[$];
  int              burst_left = 0;
  int              bytes_sent = 0;
  int              requests_sent = 0;

  always #5 clk = ~clk;

  task automatic send_byte(input logic [7:0] b, input logic s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        req_if.valid <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    req_if.valid         <= 1'b1;
    req_if.data_byte     <= b;
    req_if.start_request <= s;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(b, s);
    bytes_sent++;
    burst_left--;
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic send_text(input string s, input logic first_start);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], first_start && (i == 0));
  endtask

  function automatic void append_byte(input logic [7:0] b);
    wire_bytes = {wire_bytes, b};
  endfunction

  function automatic logic [7:0] rand_token();
    logic [7:0] b;
    do b = 8'($urandom_range(33, 126)); while (!sb.is_token(b));
    return b;
  endfunction

  function automatic logic [7:0] rand_text(input bit allow_space);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (sb.is_ctl(b) || (!allow_space && b == ASCII_SP));
    return b;
  endfunction

  function automatic void push_digits();
    int n;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 4) : $urandom_range(1, 2);
    repeat (n) append_byte(ASCII_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void push_crlf();
    append_byte(ASCII_CR);
    append_byte(ASCII_LF);
  endfunction

  function automatic void push_value();
    int n;
    n = $urandom_range(0, 8);
    repeat (n) append_byte(rand_text(1'b1));
    push_crlf();
  endfunction

  function automatic void build_request();
    int n;
    int hdrs;
    wire_bytes.delete();
    n = $urandom_range(1, 6);
    repeat (n) append_byte(rand_token());
    append_byte(ASCII_SP);
    n = $urandom_range(1, 8);
    repeat (n) append_byte(rand_text(1'b0));
    append_byte(ASCII_SP);
    append_byte(ASCII_H);
    append_byte(ASCII_T);
    append_byte(ASCII_T);
    append_byte(ASCII_P);
    append_byte(ASCII_SLASH);
    push_digits();
    append_byte(ASCII_DOT);
    push_digits();
    push_crlf();
    hdrs = $urandom_range(0, 4);
    repeat (hdrs) begin
      n = $urandom_range(1, 6);
      repeat (n) append_byte(rand_token());
      append_byte(ASCII_COLON);
      append_byte(ASCII_SP);
      push_value();
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) append_byte($urandom_range(0, 1) ? ASCII_SP : ASCII_TAB);
        push_value();
      end
    end
    push_crlf();
  endfunction

  initial begin : result_sink
    int         cyc;
    sink_mode_t mode;
    cyc  = 0;
    mode = SINK_OPEN;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready)
        sb.check_result(res_if.verdict, res_if.byte_kind, res_if.new_header,
                        res_if.char_out, res_if.version_major, res_if.version_minor);
      if (cyc % 48 == 0) mode = sink_mode_t'($urandom_range(0, 3));
      case (mode)
        SINK_OPEN:     res_if.ready <= 1'b1;
        SINK_LIGHT:    res_if.ready <= ($urandom_range(0, 3) != 0);
        SINK_HEAVY:    res_if.ready <= ($urandom_range(0, 3) == 0);
        SINK_PERIODIC: res_if.ready <= ((cyc % 8) < 5);
        default:       res_if.ready <= 1'b1;
      endcase
      cyc++;
    end
  end

  initial begin : stimulus
    int pick;
    int idx;
    int n;
    int rand_base;
    req_if.valid         <= 1'b0;
    req_if.data_byte     <= 8'd0;
    req_if.start_request <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_text("G / HTTP/9.0", 1'b1);
    send_byte(ASCII_CR, 1'b0);
    send_byte(ASCII_LF, 1'b0);
    send_byte(ASCII_SP, 1'b0);
    send_byte(ASCII_TAB, 1'b0);
    send_byte(ASCII_CR, 1'b0);
    send_byte(ASCII_LF, 1'b0);
    send_byte(8'h41, 1'b0);
    // hold until everything directed has come back
    drain_results();

    rand_base = bytes_sent;
    while (bytes_sent - rand_base < 410) begin
      pick = $urandom_range(0, 19);
      if (pick < 14 || pick >= 17) begin
        build_request();
        if (pick >= 17) begin
          idx = $urandom_range(0, wire_bytes.size() - 1);
          wire_bytes[idx] = 8'($urandom_range(0, 255));
        end
        requests_sent++;
        foreach (wire_bytes[i])
          send_byte(wire_bytes[i], (i == 0) && ($urandom_range(0, 9) != 0));
        if ($urandom_range(0, 7) == 0) drain_results();
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end

    drain_results();
    repeat (6) @(posedge clk);
    $display("tb: %0d bytes over %0d generated requests, %0d results checked",
             bytes_sent, requests_sent, sb.checked);
    $display("tb: %0d requests completed, %0d malformed bytes", sb.done_cnt, sb.bad_cnt);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/hrp_pkg.sv
rtl/hrp_if.sv
rtl/hrp_front.sv
rtl/hrp_queue.sv
rtl/hrp_back.sv
rtl/http_request_header_parser.sv
tb/tb.sv
